// ===== rtl/fipm_pkg.sv =====
// ----------------------------------------------------------------------------
// fipm_pkg: shared types and constants of the frame interval monitor
// Holds the sample width, the item type handed between sort cells, the cell
// control group and the command codes.
// ----------------------------------------------------------------------------
`default_nettype none
package fipm_pkg;

  localparam int unsigned VAL_W      = 29;
  localparam int unsigned TS_W       = 63;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CNT_OUT_W  = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned WINDOW_DEF = 256;
  localparam int unsigned LIMIT_NS   = 500000000;
  localparam int unsigned P95_NUM    = 95;
  localparam int unsigned P95_DEN    = 100;

  localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOW = 2'd1;

  // one sample moving through the sort chain
  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] val;
  } fipm_item_t;

  // control shared by every cell
  typedef struct packed {
    logic clr;  // empty the cell
    logic shf;  // move held values one cell toward the head
  } fipm_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/fipm_cell.sv =====
// ----------------------------------------------------------------------------
// fipm_cell: one insertion cell of the sort chain
// Keeps the smaller of its held and incoming sample, passes the larger on.
// ----------------------------------------------------------------------------
`default_nettype none
module fipm_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  fipm_pkg::fipm_ctl_t  ctl,
  input  fipm_pkg::fipm_item_t in_item,   // from previous cell
  input  fipm_pkg::fipm_item_t nb_item,   // held item of next cell
  output fipm_pkg::fipm_item_t held,
  output fipm_pkg::fipm_item_t pass
);

  fipm_pkg::fipm_item_t held_r, held_nxt;
  fipm_pkg::fipm_item_t pass_r, pass_nxt;

  always_comb begin
    held_nxt     = held_r;
    pass_nxt     = in_item;
    pass_nxt.vld = 1'b0;
    if (ctl.clr) begin
      held_nxt.vld = 1'b0;
    end else if (ctl.shf) begin
      held_nxt = nb_item;
    end else if (in_item.vld) begin
      if (!held_r.vld) begin
        held_nxt = in_item;
      end else if (in_item.val < held_r.val) begin
        held_nxt = in_item;
        pass_nxt = held_r;
      end else begin
        pass_nxt = in_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r.vld <= 1'b0;
      pass_r.vld <= 1'b0;
    end else begin
      held_r.vld <= held_nxt.vld;
      pass_r.vld <= pass_nxt.vld;
    end
    held_r.val <= held_nxt.val;
    pass_r.val <= pass_nxt.val;
  end

  assign held = held_r;
  assign pass = pass_r;

endmodule
`default_nettype wire

// ===== rtl/fipm_sorter.sv =====
// ----------------------------------------------------------------------------
// fipm_sorter: row of insertion cells
// Samples enter at the head one per cycle and settle in ascending order;
// a shift then streams them out smallest first at the head.
// ----------------------------------------------------------------------------
`default_nettype none
module fipm_sorter #(
  parameter int unsigned WINDOW = fipm_pkg::WINDOW_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  fipm_pkg::fipm_ctl_t  ctl,
  input  fipm_pkg::fipm_item_t feed,
  output fipm_pkg::fipm_item_t head
);

  fipm_pkg::fipm_item_t held_w [WINDOW];
  fipm_pkg::fipm_item_t pass_w [WINDOW];
  fipm_pkg::fipm_item_t tail_empty;

  assign tail_empty = '0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    fipm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .in_item ((i == 0) ? feed : pass_w[(i == 0) ? 0 : i - 1]),
      .nb_item ((i == WINDOW - 1) ? tail_empty : held_w[(i == WINDOW - 1) ? i : i + 1]),
      .held    (held_w[i]),
      .pass    (pass_w[i])
    );
  end

  assign head = held_w[0];

endmodule
`default_nettype wire

// ===== rtl/frame_interval_percentile_monitor.sv =====
// ----------------------------------------------------------------------------
// frame_interval_percentile_monitor: sliding window frame interval stats
// Tracks intervals between frame timestamps and reports p50 / p95.
// ----------------------------------------------------------------------------
// Usage:
//   Input items carry cmd (frame event, clear, report) and a 63-bit
//   nanosecond timestamp. Frame events while enabled store the interval to
//   the previous timestamp in a ring of the newest max_window samples when
//   it lies in 1..499999999 ns. Clear empties the window and forgets the
//   last timestamp. Only report emits an item: median, p95 and count.
//   A report on n samples runs in steps: n ring reads feed a row of
//   WINDOW insertion cells, the row settles, then shifts move the sorted
//   samples out past the percentile capture. An empty window skips the
//   sort and reports zeros. in_tready is low while a report runs and
//   while its result waits for a full output register.
//   A stalled receiver holds the result in the output register; frame
//   events and clears are still taken meanwhile.
//   Reset (synchronous, rst_n low) disables the block, empties the window
//   and sets max_window to WINDOW. The ring needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module frame_interval_percentile_monitor #(
  parameter int unsigned WINDOW = fipm_pkg::WINDOW_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [71:0] in_tdata,   // [1:0] cmd, [64:2] timestamp_ns, rest zero
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata,  // [28:0] median_ns, [57:29] p95_ns,
                                  // [66:58] sample_count, rest zero
  input  wire         cfg_we,
  input  wire  [fipm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [fipm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned KW = CW + 1;        // phase counter, up to WINDOW + 1
  localparam int unsigned PW = CW + 7;        // scaled p95 index compare
  localparam int unsigned VW = fipm_pkg::VAL_W;
  localparam int unsigned TW = fipm_pkg::TS_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_SHIFT = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  // ring index add with wrap at WINDOW
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW + 1)'(a) + (CW + 1)'(b);
    if (s >= (CW + 1)'(WINDOW)) s = s - (CW + 1)'(WINDOW);
    return AW'(s);
  endfunction

  // unpack input item
  logic [fipm_pkg::CMD_W-1:0] cmd;
  logic [TW-1:0]              ts;
  assign cmd = in_tdata[1:0];
  assign ts  = in_tdata[64:2];

  state_t          state_r, state_nxt;
  logic [AW-1:0]   oldest_r, oldest_nxt;
  logic [CW-1:0]   held_r, held_nxt;
  logic [CW-1:0]   maxw_r, maxw_nxt;
  logic            en_r, en_nxt;
  logic [TW-1:0]   prev_r, prev_nxt;
  logic            pvld_r, pvld_nxt;
  logic [VW-1:0]   med_r, med_nxt;
  logic [VW-1:0]   p95_r, p95_nxt;
  logic [KW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   half_r, half_nxt;
  logic [PW-1:0]   prod_r, prod_nxt;
  logic [PW-1:0]   sum_r, sum_nxt;
  logic            ovld_r, ovld_nxt;
  logic [71:0]     odata_r, odata_nxt;

  logic            accept;
  logic [TW-1:0]   dt;
  logic            dt_ok;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  logic            mem_re;
  logic [VW-1:0]   rdata_r;
  logic            feed_v_r;
  logic [VW-1:0]   ring_mem [WINDOW];
  logic [31:0]     cfg_w32;
  logic [CW-1:0]   last;

  fipm_pkg::fipm_ctl_t  ctl;
  fipm_pkg::fipm_item_t feed;
  fipm_pkg::fipm_item_t head;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign dt        = ts - prev_r;
  assign dt_ok     = pvld_r && (ts > prev_r) && (dt < TW'(fipm_pkg::LIMIT_NS));
  assign last      = held_r - CW'(1);
  assign cfg_w32   = 32'(cfg_data);

  assign mem_we    = accept && (cmd == fipm_pkg::CMD_FRAME) && en_r && dt_ok;
  assign mem_waddr = ring_add(oldest_r, held_r);
  assign mem_re    = (state_r == ST_LOAD) && (cnt_r < KW'(held_r));
  assign mem_raddr = ring_add(oldest_r, CW'(cnt_r));

  // ring store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[mem_waddr] <= dt[VW-1:0];
    if (mem_re) rdata_r <= ring_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) feed_v_r <= 1'b0;
    else        feed_v_r <= mem_re;
  end

  assign feed.vld = feed_v_r;
  assign feed.val = rdata_r;
  assign ctl.clr  = accept && (cmd == fipm_pkg::CMD_REPORT);
  assign ctl.shf  = (state_r == ST_SHIFT);

  fipm_sorter #(.WINDOW(WINDOW)) u_sorter (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .feed  (feed),
    .head  (head)
  );

  always_comb begin
    state_nxt  = state_r;
    oldest_nxt = oldest_r;
    held_nxt   = held_r;
    maxw_nxt   = maxw_r;
    en_nxt     = en_r;
    prev_nxt   = prev_r;
    pvld_nxt   = pvld_r;
    med_nxt    = med_r;
    p95_nxt    = p95_r;
    cnt_nxt    = cnt_r;
    half_nxt   = half_r;
    prod_nxt   = prod_r;
    sum_nxt    = sum_r;
    ovld_nxt   = ovld_r;
    odata_nxt  = odata_r;

    if (ovld_r && out_tready) ovld_nxt = 1'b0;

    // register writes: enable change forgets the timestamp, a lower
    // window drops the oldest samples
    if (cfg_we) begin
      case (cfg_index)
        fipm_pkg::REG_ENABLED: begin
          if (cfg_data[0] != en_r) begin
            en_nxt   = cfg_data[0];
            pvld_nxt = 1'b0;
          end
        end
        fipm_pkg::REG_MAX_WINDOW: begin
          if (cfg_w32 != 32'd0) begin
            maxw_nxt = (cfg_w32 > 32'(WINDOW)) ? CW'(WINDOW) : CW'(cfg_w32);
            if (held_r > maxw_nxt) begin
              oldest_nxt = ring_add(oldest_r, held_r - maxw_nxt);
              held_nxt   = maxw_nxt;
            end
          end
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            fipm_pkg::CMD_FRAME: begin
              if (en_r) begin
                if (dt_ok) begin
                  if (held_r >= maxw_r) oldest_nxt = ring_add(oldest_r, CW'(1));
                  else                  held_nxt   = held_r + CW'(1);
                end
                prev_nxt = ts;
                pvld_nxt = 1'b1;
              end
            end
            fipm_pkg::CMD_CLEAR: begin
              oldest_nxt = '0;
              held_nxt   = '0;
              med_nxt    = '0;
              p95_nxt    = '0;
              pvld_nxt   = 1'b0;
            end
            fipm_pkg::CMD_REPORT: begin
              cnt_nxt  = '0;
              sum_nxt  = '0;
              half_nxt = last >> 1;
              prod_nxt = PW'(last) * PW'(fipm_pkg::P95_NUM);
              if (held_r == '0) begin
                med_nxt   = '0;
                p95_nxt   = '0;
                state_nxt = ST_OUT;
              end else begin
                state_nxt = ST_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD: begin
        // issue one ring read per cycle, oldest first
        if (cnt_r == KW'(held_r)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + KW'(1);
        end
      end
      ST_DRAIN: begin
        // let the last sample ripple to its place
        if (cnt_r == KW'(WINDOW + 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SHIFT;
        end else begin
          cnt_nxt = cnt_r + KW'(1);
        end
      end
      ST_SHIFT: begin
        // head shows sorted index cnt; keep the last index under each bound
        if (cnt_r <= KW'(half_r)) med_nxt = head.val;
        if (sum_r <= prod_r)      p95_nxt = head.val;
        sum_nxt = sum_r + PW'(fipm_pkg::P95_DEN);
        cnt_nxt = cnt_r + KW'(1);
        if (cnt_r == KW'(last)) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ovld_r || out_tready) begin
          ovld_nxt         = 1'b1;
          odata_nxt        = '0;
          odata_nxt[28:0]  = med_r;
          odata_nxt[57:29] = p95_r;
          odata_nxt[66:58] = fipm_pkg::CNT_OUT_W'(held_r);
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      oldest_r <= '0;
      held_r   <= '0;
      maxw_r   <= CW'(WINDOW);
      en_r     <= 1'b0;
      prev_r   <= '0;
      pvld_r   <= 1'b0;
      med_r    <= '0;
      p95_r    <= '0;
      cnt_r    <= '0;
      ovld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      held_r   <= held_nxt;
      maxw_r   <= maxw_nxt;
      en_r     <= en_nxt;
      prev_r   <= prev_nxt;
      pvld_r   <= pvld_nxt;
      med_r    <= med_nxt;
      p95_r    <= p95_nxt;
      cnt_r    <= cnt_nxt;
      ovld_r   <= ovld_nxt;
    end
    half_r  <= half_nxt;
    prod_r  <= prod_nxt;
    sum_r   <= sum_nxt;
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

  a_held_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= maxw_r)
    else $error("held count above window size");

  a_oldest_range: assert property (@(posedge clk) disable iff (!rst_n)
    oldest_r < AW'(WINDOW - 1) || oldest_r == AW'(WINDOW - 1))
    else $error("oldest slot outside ring");

  a_maxw_range: assert property (@(posedge clk) disable iff (!rst_n)
    maxw_r != '0 && maxw_r <= CW'(WINDOW))
    else $error("window size out of range");

  a_report_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> held_r != '0)
    else $error("sort started on empty window");

endmodule
`default_nettype wire
